// ===== rtl/qsl_pkg.sv =====
// ----------------------------------------------------------------------------
// qsl_pkg: shared types and constants for the quicksort sorter
// Holds the sequencer state type, the value width and a signed compare.
// ----------------------------------------------------------------------------
package qsl_pkg;

   localparam int VALUE_W = 32;

   // sequencer states, one-hot
   typedef enum logic [10:0] {
      ST_LOAD   = 11'b000_0000_0001,
      ST_PIVOT  = 11'b000_0000_0010,
      ST_SCAN   = 11'b000_0000_0100,
      ST_SWAPW  = 11'b000_0000_1000,
      ST_FINRD  = 11'b000_0001_0000,
      ST_FINW1  = 11'b000_0010_0000,
      ST_FINW2  = 11'b000_0100_0000,
      ST_SPLIT  = 11'b000_1000_0000,
      ST_POP    = 11'b001_0000_0000,
      ST_OUTRD  = 11'b010_0000_0000,
      ST_OUT    = 11'b100_0000_0000
   } state_type;

   // signed compare of two raw words
   function automatic logic less_than(input logic [VALUE_W-1:0] a,
                                      input logic [VALUE_W-1:0] b);
      less_than = $signed(a) < $signed(b);
   endfunction

endpackage

// ===== rtl/qsl_ram.sv =====
// ----------------------------------------------------------------------------
// qsl_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module qsl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata_ff <= mem[addr];
   end
   assign rdata = rdata_ff;
endmodule

// ===== rtl/quicksort_lomuto_sorter_core.sv =====
// ----------------------------------------------------------------------------
// quicksort_lomuto_sorter_core: in-place quicksort of signed 32-bit words
// Loads a set, sorts it with Lomuto partitions, streams it back out.
// ----------------------------------------------------------------------------
// Usage:
//   Input words enter with start high while busy is low, one word per cycle
//   while loading. A word with req_final_item high closes the set.
//   Words beyond MAX_ITEMS are dropped, but their final mark still counts.
//   The set is then sorted in place in a single-port element RAM. A
//   partition reads the pivot at the top of its range, scans each word,
//   swaps smaller words to the front and then moves the pivot into place;
//   already ordered data sorts slowest (the RAM port is the limit), and
//   each popped range adds a pop step.
//   Results then come out as rsp_valid strobes, never back to back,
//   with rsp_final_item marking the last. A one-word set skips the sort
//   and goes straight to output. busy is high from the final word until
//   the last strobe, which shows with busy already low.
//   The receiver cannot stall the output.
//   Reset (synchronous, active high) empties the set and the range stack;
//   no clearing pass is needed.
// ----------------------------------------------------------------------------
module quicksort_lomuto_sorter_core
   import qsl_pkg::*;
#(
   parameter int MAX_ITEMS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_value,
   input  logic               req_final_item,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_value_res,
   output logic               rsp_final_item_res
);
   localparam int AW = $clog2(MAX_ITEMS);
   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam int SD = (AW < 1) ? 1 : AW;
   localparam int SPW = $clog2(SD + 1);
   localparam int SIW = (SD > 1) ? $clog2(SD) : 1;
   localparam logic [AW:0] ONE_W = (AW+1)'(1);

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] lo_ff, lo_in, hi_ff, hi_in, j_ff, j_in, dst_ff, dst_in;
   logic [VALUE_W-1:0] pivot_ff, pivot_in, tmp_ff, tmp_in;
   logic [AW-1:0] slo_ff [SD];
   logic [AW-1:0] shi_ff [SD];
   logic [SPW-1:0] sp_ff, sp_in;
   logic push_en;
   logic [AW-1:0] push_lo, push_hi;
   logic rsp_valid_ff, rsp_valid_in, rsp_fin_ff, rsp_fin_in;
   logic [VALUE_W-1:0] rsp_val_ff, rsp_val_in;
   // first scan cycle after a pivot read: rdata holds store[hi]
   logic first_ff;

   logic we;
   logic [AW-1:0] addr;
   logic [VALUE_W-1:0] wdata, rdata;

   qsl_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_ITEMS)) u_store (
      .clock(clock), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata));

   assign busy = (state_ff != ST_LOAD);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_value_res = rsp_val_ff;
   assign rsp_final_item_res = rsp_fin_ff;

   // sequencer
   always_comb begin
      logic [AW:0] left_len, right_len, dst_w, lo_w, hi_w;
      state_in = state_ff; count_in = count_ff; lo_in = lo_ff; hi_in = hi_ff;
      j_in = j_ff; dst_in = dst_ff; pivot_in = pivot_ff; tmp_in = tmp_ff;
      sp_in = sp_ff; push_en = 1'b0; push_lo = '0; push_hi = '0;
      we = 1'b0; addr = j_ff; wdata = tmp_ff;
      rsp_valid_in = 1'b0; rsp_val_in = rsp_val_ff; rsp_fin_in = rsp_fin_ff;
      dst_w = {1'b0, dst_ff};
      lo_w = {1'b0, lo_ff};
      hi_w = {1'b0, hi_ff};
      left_len = dst_w - lo_w;
      right_len = hi_w - dst_w;
      case (state_ff)
         ST_LOAD: begin
            addr = count_ff[AW-1:0];
            wdata = req_value;
            if (start) begin
               if (count_ff < CW'(MAX_ITEMS)) begin
                  we = 1'b1;
                  count_in = count_ff + CW'(1);
               end
               if (req_final_item) begin
                  lo_in = '0;
                  hi_in = AW'(((count_ff < CW'(MAX_ITEMS)) ? count_ff : count_ff - CW'(1)));
                  sp_in = '0;
                  j_in = '0;
                  // single word set: emit directly
                  if (count_ff == '0) state_in = ST_OUTRD;
                  else state_in = ST_PIVOT;
               end
            end
         end
         ST_PIVOT: begin
            // read pivot at hi; lo < hi holds here
            addr = hi_ff;
            j_in = lo_ff; dst_in = lo_ff;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (first_ff) pivot_in = rdata;
            if (j_ff == hi_ff) begin
               // scan done: pivot goes to dst
               state_in = ST_FINRD;
            end else begin
               addr = j_ff;
               state_in = ST_SWAPW;
            end
         end
         ST_SWAPW: begin
            // rdata = store[j]; compare against pivot
            if (less_than(rdata, pivot_ff)) begin
               tmp_in = rdata;
               addr = dst_ff;
               state_in = ST_FINW1;
            end else begin
               j_in = j_ff + AW'(1);
               state_in = ST_SCAN;
            end
         end
         ST_FINRD: begin
            addr = dst_ff;
            tmp_in = pivot_ff;
            state_in = ST_FINW1;
         end
         ST_FINW1: begin
            // rdata = store[dst]; move it to j, then tmp to dst
            we = 1'b1; addr = j_ff; wdata = rdata;
            state_in = ST_FINW2;
         end
         ST_FINW2: begin
            we = 1'b1; addr = dst_ff; wdata = tmp_ff;
            if (j_ff == hi_ff) state_in = ST_SPLIT;
            else begin
               dst_in = dst_ff + AW'(1);
               j_in = j_ff + AW'(1);
               state_in = ST_SCAN;
            end
         end
         ST_SPLIT: begin
            // push the larger side, keep working on the smaller one
            if (left_len < right_len) begin
               if (dst_w + ONE_W < hi_w) begin
                  push_en = 1'b1; push_lo = dst_ff + AW'(1); push_hi = hi_ff;
               end
               if (dst_w > lo_w + ONE_W) begin
                  hi_in = dst_ff - AW'(1); state_in = ST_PIVOT;
               end else state_in = ST_POP;
            end else begin
               if (dst_w > lo_w + ONE_W) begin
                  push_en = 1'b1; push_lo = lo_ff; push_hi = dst_ff - AW'(1);
               end
               if (dst_w + ONE_W < hi_w) begin
                  lo_in = dst_ff + AW'(1); state_in = ST_PIVOT;
               end else state_in = ST_POP;
            end
            if (push_en && sp_ff < SPW'(SD)) sp_in = sp_ff + SPW'(1);
            else push_en = 1'b0;
         end
         ST_POP: begin
            if (sp_ff == '0) begin
               j_in = '0; state_in = ST_OUTRD;
            end else begin
               sp_in = sp_ff - SPW'(1);
               lo_in = slo_ff[SIW'(sp_ff - SPW'(1))];
               hi_in = shi_ff[SIW'(sp_ff - SPW'(1))];
               state_in = ST_PIVOT;
            end
         end
         ST_OUTRD: begin
            addr = j_ff;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_val_in = rdata;
            rsp_fin_in = (CW'(j_ff) + CW'(1) == count_ff);
            if (CW'(j_ff) + CW'(1) == count_ff) begin
               count_in = '0; state_in = ST_LOAD;
            end else begin
               j_in = j_ff + AW'(1); state_in = ST_OUTRD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) first_ff <= 1'b0;
      else first_ff <= (state_ff == ST_PIVOT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD; count_ff <= '0; sp_ff <= '0; rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; sp_ff <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in; hi_ff <= hi_in; j_ff <= j_in; dst_ff <= dst_in;
      pivot_ff <= pivot_in; tmp_ff <= tmp_in;
      rsp_val_ff <= rsp_val_in; rsp_fin_ff <= rsp_fin_in;
      if (push_en) begin
         slo_ff[sp_ff[SIW-1:0]] <= push_lo;
         shi_ff[sp_ff[SIW-1:0]] <= push_hi;
      end
   end
endmodule

// ===== rtl/qsl_checker.sv =====
// ----------------------------------------------------------------------------
// qsl_checker: port-level checks for the quicksort sorter
// Watches handshake and result framing on the top-level ports.
// ----------------------------------------------------------------------------
module qsl_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_final_item,
   input logic rsp_valid,
   input logic rsp_final_item_res
);
   // results appear only while busy or as the last strobe as busy falls
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("result while idle");
   // a final word makes the block busy
   a_final_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_final_item) |=> busy) else $error("no sort after final");
   // strobes are never back to back
   a_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("back to back results");
   // last result returns the block to idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_final_item_res) |-> !busy) else $error("busy after last");
endmodule

bind quicksort_lomuto_sorter_core qsl_checker u_qsl_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .req_final_item(req_final_item), .rsp_valid(rsp_valid),
   .rsp_final_item_res(rsp_final_item_res));
